// ===== rtl/pakc_pkg.sv =====
package pakc_pkg;

  localparam int unsigned KeyMax   = 32;
  localparam int unsigned KeyPosW  = $clog2(KeyMax);
  localparam int unsigned KeyLenW  = 6;
  localparam int unsigned CharW    = 8;
  localparam int unsigned KeyRegW  = 64;
  localparam int unsigned KeyRegs  = 4;
  localparam int unsigned PaddrW   = 6;
  localparam int unsigned PdataW   = 64;
  localparam int unsigned BitIdxW  = 3;

  typedef enum logic {
    MODE_ENC = 1'b0,
    MODE_DEC = 1'b1
  } mode_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_RESTART = 1'b1
  } kind_e;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_KEY_LEN = 3'd1;
  localparam logic [2:0] REG_KEY_0   = 3'd2;
  localparam logic [2:0] REG_KEY_1   = 3'd3;
  localparam logic [2:0] REG_KEY_2   = 3'd4;
  localparam logic [2:0] REG_KEY_3   = 3'd5;

  localparam logic [CharW-1:0] CharTab  = 8'd9;
  localparam logic [CharW-1:0] CharLow  = 8'd31;
  localparam logic [CharW-1:0] CharCtl  = 8'd30;
  localparam logic [CharW-1:0] CharZero = 8'd48;

endpackage

// ===== rtl/pakc_in_if.sv =====
interface pakc_in_if;
  import pakc_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [CharW-1:0] char_in;

  modport source (output valid, output kind, output char_in, input ready);
  modport sink   (input valid, input kind, input char_in, output ready);

endinterface

// ===== rtl/pakc_out_if.sv =====
interface pakc_out_if;
  import pakc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] byte_out;
  logic             last;

  modport source (output valid, output byte_out, output last, input ready);
  modport sink   (input valid, input byte_out, input last, output ready);

endinterface

// ===== rtl/printable_ascii_keyed_shift_cipher.sv =====
// Keyed shift cipher over printable ASCII with binary-text ciphertext. Items pass through an
// input register, are shifted combinationally by the current key byte, and land in a result
// register that also serialises the output. In encrypt mode every data item gives eight
// '0'/'1' result items, MSB first, and the next item waits in the input register until all
// eight are sent; in decrypt mode and for restart items intake is one item per cycle unless
// a finished group waits on a busy result register, with one result per eighth digit. Key and
// mode registers sit on a 64-bit APB port at byte address 8*index; write them only while idle.
module printable_ascii_keyed_shift_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pakc_pkg::PaddrW-1:0]   paddr,
  input  logic [pakc_pkg::PdataW-1:0]   pwdata,
  output logic [pakc_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  pakc_in_if.sink                       in_i,
  pakc_out_if.source                    out_o
);
  import pakc_pkg::*;

  function automatic logic passes(input logic [CharW-1:0] c);
    return ((c <= CharCtl) && (c != CharTab)) || c[CharW-1];
  endfunction

  mode_e                           mode_q;
  logic [KeyLenW-1:0]              key_len_q;
  logic [KeyRegs-1:0][KeyRegW-1:0] key_q;

  logic             s1_valid_q;
  logic             s1_kind_q;
  logic [CharW-1:0] s1_char_q;

  logic [KeyPosW-1:0] kpos_q, kpos_d;
  logic [2:0]         dcnt_q, dcnt_d;
  logic [CharW-1:0]   acc_q, acc_d;

  logic               s2_valid_q, s2_valid_d;
  logic               s2_enc_q, s2_enc_d;
  logic [CharW-1:0]   s2_byte_q, s2_byte_d;
  logic [BitIdxW-1:0] s2_idx_q, s2_idx_d;

  logic               wr_en;
  logic [2:0]         wr_idx;
  logic [KeyMax*CharW-1:0] key_flat;
  logic [CharW-1:0]   kbyte;
  logic signed [9:0]  kval;
  logic [CharW-1:0]   digit;
  logic [CharW-1:0]   acc_new;
  logic               grp_done;
  logic               is_enc;
  logic [CharW-1:0]   src;
  logic               pass;
  logic signed [9:0]  vval;
  logic signed [9:0]  sval;
  logic [9:0]         tval;
  logic [8:0]         mval;
  logic [CharW-1:0]   eval;
  logic [CharW-1:0]   res_byte;
  logic               is_data;
  logic               has_result;
  logic               advance;
  logic [KeyLenW-1:0] len_eff;
  logic [KeyLenW-1:0] pos_inc;
  logic               out_fire;
  logic               s2_free;
  logic               s1_move;

  // configuration
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_ENC;
      key_len_q <= KeyLenW'(1);
      key_q     <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_MODE:    mode_q    <= mode_e'(pwdata[0]);
        REG_KEY_LEN: key_len_q <= pwdata[KeyLenW-1:0];
        REG_KEY_0:   key_q[0]  <= pwdata;
        REG_KEY_1:   key_q[1]  <= pwdata;
        REG_KEY_2:   key_q[2]  <= pwdata;
        REG_KEY_3:   key_q[3]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_MODE:    prdata = PdataW'(mode_q);
      REG_KEY_LEN: prdata = PdataW'(key_len_q);
      REG_KEY_0:   prdata = key_q[0];
      REG_KEY_1:   prdata = key_q[1];
      REG_KEY_2:   prdata = key_q[2];
      REG_KEY_3:   prdata = key_q[3];
      default:     prdata = '0;
    endcase
  end

  // handshake
  assign out_fire   = out_o.valid && out_o.ready;
  assign s2_free    = !s2_valid_q || (out_fire && out_o.last);
  assign s1_move    = s1_valid_q && (!has_result || s2_free);
  assign in_i.ready = !s1_valid_q || s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_kind_q <= in_i.kind;
      s1_char_q <= in_i.char_in;
    end
  end

  // shift
  assign key_flat = key_q;
  assign kbyte    = key_flat[kpos_q*CharW +: CharW];
  assign kval     = kbyte[7] ? $signed({2'b00, kbyte}) - 10'sd130 : $signed({2'b00, kbyte});

  assign is_enc   = (mode_q == MODE_ENC);
  assign is_data  = (s1_kind_q == KIND_DATA);
  assign digit    = s1_char_q - CharZero;
  assign acc_new  = acc_q + (digit << (3'd7 - dcnt_q));
  assign grp_done = (dcnt_q == 3'd7);
  assign src      = is_enc ? s1_char_q : acc_new;
  assign pass     = passes(src);
  assign vval     = (src == CharTab) ? $signed({2'b00, CharLow}) : $signed({2'b00, src});
  assign sval     = is_enc ? vval + kval - 10'sd61 : vval - kval - 10'sd1;
  assign tval     = 10'($unsigned(sval + 10'sd192));

  always_comb begin
    if (tval >= 10'd384) begin
      mval = 9'(tval - 10'd384);
    end else if (tval >= 10'd288) begin
      mval = 9'(tval - 10'd288);
    end else if (tval >= 10'd192) begin
      mval = 9'(tval - 10'd192);
    end else if (tval >= 10'd96) begin
      mval = 9'(tval - 10'd96);
    end else begin
      mval = tval[8:0];
    end
    eval = CharW'(mval) + CharLow;
    if (eval == CharLow) begin
      eval = CharTab;
    end
    res_byte = pass ? src : eval;
  end

  assign has_result = is_data && (is_enc || grp_done);
  assign advance    = has_result && !pass;

  always_comb begin
    if (key_len_q == '0) begin
      len_eff = KeyLenW'(1);
    end else if (key_len_q > KeyLenW'(KeyMax)) begin
      len_eff = KeyLenW'(KeyMax);
    end else begin
      len_eff = key_len_q;
    end
    pos_inc = KeyLenW'(kpos_q) + KeyLenW'(1);
  end

  always_comb begin
    kpos_d = kpos_q;
    dcnt_d = dcnt_q;
    acc_d  = acc_q;
    if (s1_move) begin
      if (!is_data) begin
        kpos_d = '0;
        dcnt_d = '0;
        acc_d  = '0;
      end else begin
        if (!is_enc) begin
          dcnt_d = dcnt_q + 3'd1;
          acc_d  = grp_done ? '0 : acc_new;
        end
        if (advance) begin
          kpos_d = (pos_inc >= len_eff) ? '0 : pos_inc[KeyPosW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kpos_q <= '0;
      dcnt_q <= '0;
      acc_q  <= '0;
    end else begin
      kpos_q <= kpos_d;
      dcnt_q <= dcnt_d;
      acc_q  <= acc_d;
    end
  end

  // result register and serialiser
  always_comb begin
    s2_valid_d = s2_valid_q;
    s2_enc_d   = s2_enc_q;
    s2_byte_d  = s2_byte_q;
    s2_idx_d   = s2_idx_q;
    if (out_fire) begin
      if (out_o.last) begin
        s2_valid_d = 1'b0;
      end else begin
        s2_idx_d  = s2_idx_q + BitIdxW'(1);
        s2_byte_d = s2_byte_q << 1;
      end
    end
    if (s1_move && has_result) begin
      s2_valid_d = 1'b1;
      s2_enc_d   = is_enc;
      s2_byte_d  = res_byte;
      s2_idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_idx_q   <= '0;
    end else begin
      s2_valid_q <= s2_valid_d;
      s2_idx_q   <= s2_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_enc_q  <= s2_enc_d;
    s2_byte_q <= s2_byte_d;
  end

  assign out_o.valid    = s2_valid_q;
  assign out_o.byte_out = s2_enc_q ? (CharZero | CharW'(s2_byte_q[CharW-1])) : s2_byte_q;
  assign out_o.last     = !s2_enc_q || (s2_idx_q == BitIdxW'(7));

  // checks
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && !is_data |=> (kpos_q == '0) && (dcnt_q == '0) && (acc_q == '0))
    else $error("restart did not clear key position and digit group");

  a_dec_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !s2_enc_q |-> out_o.last && (s2_idx_q == '0))
    else $error("decrypt result not a single last item");

  a_serial_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && (s2_idx_q != '0) |-> $past(s2_valid_q) && $past(s2_enc_q))
    else $error("serialiser resumed without a running item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !(out_fire && out_o.last) |-> !(s1_move && has_result))
    else $error("result register overwritten while busy");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && advance |=> (KeyLenW'(kpos_q) < $past(len_eff)))
    else $error("key position beyond key length after advance");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import pakc_pkg::*;

  localparam int unsigned PipeLatency   = 2;
  localparam int unsigned SettleCycles  = PipeLatency + 6;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned ItemsPerBatch = 20;
  localparam int unsigned BatchesPerMix = 5;

  typedef struct packed {
    logic [CharW-1:0] byte_out;
    logic             last;
  } cipher_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  pakc_in_if  in_if ();
  pakc_out_if out_if ();

  printable_ascii_keyed_shift_cipher dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // shadow of the block's registers and cipher state
  mode_e              cfg_mode    = MODE_ENC;
  logic [KeyLenW-1:0] cfg_key_len = KeyLenW'(1);
  logic [KeyRegW-1:0] cfg_key [KeyRegs];
  logic [KeyPosW-1:0] key_pos     = '0;
  logic [BitIdxW-1:0] digit_cnt   = '0;
  logic [CharW-1:0]   digit_acc   = '0;

  cipher_out_t expected_q [$];
  cipher_out_t exp_item;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned stall_count   = 0;
  int          fail_count    = 0;
  logic        holding       = 1'b0;
  event        hold_start;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit is_passthrough(logic [CharW-1:0] c);
    return (c <= CharCtl && c != CharTab) || c[CharW-1];
  endfunction

  function automatic int key_shift();
    logic [CharW-1:0] b;
    b = cfg_key[key_pos[KeyPosW-1:3]][key_pos[2:0]*8 +: 8];
    return b[CharW-1] ? int'(b) - 256 + 126 : int'(b);
  endfunction

  function automatic logic [CharW-1:0] wrap_printable(int s);
    int m;
    m = s % 96;
    if (m < 0) m += 96;
    m += 31;
    return (m == int'(CharLow)) ? CharTab : CharW'(m);
  endfunction

  function automatic void step_key_pos();
    int len;
    len = int'(cfg_key_len);
    if (len == 0) len = 1;
    if (len > int'(KeyMax)) len = KeyMax;
    key_pos = (int'(key_pos) + 1 >= len) ? '0 : key_pos + 1'b1;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [PdataW-1:0] val);
    case (idx)
      REG_MODE:    cfg_mode = mode_e'(val[0]);
      REG_KEY_LEN: cfg_key_len = val[KeyLenW-1:0];
      REG_KEY_0:   cfg_key[0] = val;
      REG_KEY_1:   cfg_key[1] = val;
      REG_KEY_2:   cfg_key[2] = val;
      REG_KEY_3:   cfg_key[3] = val;
      default: ;
    endcase
  endfunction

  function automatic void predict_cipher(kind_e k, logic [CharW-1:0] ch);
    logic [CharW-1:0] c;
    logic [CharW-1:0] d;
    cipher_out_t      r;
    if (k == KIND_RESTART) begin
      key_pos   = '0;
      digit_cnt = '0;
      digit_acc = '0;
      return;
    end
    if (cfg_mode == MODE_ENC) begin
      if (is_passthrough(ch)) begin
        c = ch;
      end else begin
        c = wrap_printable(int'((ch == CharTab) ? CharLow : ch) + key_shift() - 61);
        step_key_pos();
      end
      for (int i = 7; i >= 0; i--) begin
        r.byte_out = CharZero + CharW'(c[i]);
        r.last     = (i == 0);
        expected_q.push_back(r);
      end
      return;
    end
    d = ch - CharZero;
    d = d << (3'd7 - digit_cnt);
    digit_acc = digit_acc + d;
    digit_cnt = digit_cnt + 1'b1;
    if (digit_cnt != '0) return;
    c = digit_acc;
    digit_acc = '0;
    if (!is_passthrough(c)) begin
      c = wrap_printable(int'((c == CharTab) ? CharLow : c) - key_shift() - 1);
      step_key_pos();
    end
    r.byte_out = c;
    r.last     = 1'b1;
    expected_q.push_back(r);
  endfunction

  task automatic send_item(kind_e k, logic [CharW-1:0] ch);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= k;
    in_if.char_in <= ch;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_cipher(k, ch);
  endtask

  task automatic send_digits(logic [CharW-1:0] b);
    for (int i = 7; i >= 0; i--) send_item(KIND_DATA, b[i] ? "1" : "0");
  endtask

  // drop valid and let every outstanding item drain
  task automatic drain_block();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [PdataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic write_config(mode_e m, logic [KeyLenW-1:0] len, logic [KeyRegW-1:0] k0,
                              logic [KeyRegW-1:0] k1, logic [KeyRegW-1:0] k2,
                              logic [KeyRegW-1:0] k3);
    write_reg(REG_MODE, PdataW'(m));
    write_reg(REG_KEY_LEN, PdataW'(len));
    write_reg(REG_KEY_0, k0);
    write_reg(REG_KEY_1, k1);
    write_reg(REG_KEY_2, k2);
    write_reg(REG_KEY_3, k3);
  endtask

  function automatic logic [KeyRegW-1:0] pick_key_word();
    logic [KeyRegW-1:0] w;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(4))
        0:       w[i*8 +: 8] = 8'h00;
        1:       w[i*8 +: 8] = 8'h7F;
        2:       w[i*8 +: 8] = 8'h80;
        3:       w[i*8 +: 8] = 8'hFF;
        default: w[i*8 +: 8] = 8'($urandom);
      endcase
    end
    return w;
  endfunction

  function automatic logic [KeyLenW-1:0] pick_key_len();
    case ($urandom_range(9))
      0:       return '0;
      1:       return KeyLenW'(1);
      2:       return KeyLenW'(KeyMax);
      3:       return '1;
      4:       return KeyLenW'(KeyMax + 8);
      default: return KeyLenW'($urandom_range(KeyMax, 1));
    endcase
  endfunction

  task automatic test_encrypt_extremes();
    write_config(MODE_ENC, KeyLenW'(3), 64'h0000_0000_007F_FF80, '1, '0, 64'h8000_0000_0000_007F);
    send_item(KIND_DATA, 8'd0);
    send_item(KIND_DATA, CharTab);
    send_item(KIND_DATA, CharCtl);
    send_item(KIND_DATA, CharLow);
    send_item(KIND_DATA, 8'd126);
    send_item(KIND_DATA, 8'd127);
    send_item(KIND_DATA, 8'd128);
    send_item(KIND_DATA, 8'd255);
    send_item(KIND_RESTART, 8'hFF);
    send_item(KIND_DATA, "A");
    drain_block();
  endtask

  task automatic test_decrypt_groups();
    write_config(MODE_DEC, KeyLenW'(2), 64'h0000_0000_0000_80FF, '0, '0, '0);
    send_digits(CharTab);
    send_item(KIND_DATA, "0");
    send_item(KIND_DATA, "1");
    send_item(KIND_DATA, "1");
    send_item(KIND_RESTART, 8'h00);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, "a");
    send_item(KIND_DATA, "2");
    send_item(KIND_DATA, "0");
    send_item(KIND_DATA, "1");
    send_item(KIND_DATA, " ");
    send_item(KIND_DATA, "Z");
    drain_block();
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_config(MODE_ENC, KeyLenW'(5), pick_key_word(), pick_key_word(), '0, '0);
    -> hold_start;
    for (int i = 0; i < 40; i++) send_item(KIND_DATA, 8'($urandom_range(127, 31)));
    // hold the sender until every result is out
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 20; i++) send_item(KIND_DATA, 8'($urandom));
    drain_block();
  endtask

  task automatic send_random_items(int unsigned n_items);
    int unsigned      sent;
    int unsigned      pick;
    logic [CharW-1:0] b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (cfg_mode == MODE_ENC) begin
        if (pick < 75)      send_item(KIND_DATA, 8'($urandom_range(127, 31)));
        else if (pick < 85) send_item(KIND_DATA, CharTab);
        else if (pick < 95) send_item(KIND_DATA, 8'($urandom));
        else                send_item(KIND_RESTART, 8'($urandom));
        sent++;
      end else if (pick < 70) begin
        case ($urandom_range(9))
          0, 1:    b = 8'($urandom);
          2:       b = CharTab;
          3:       b = CharLow;
          default: b = 8'($urandom_range(127, 32));
        endcase
        send_digits(b);
        sent += 8;
      end else begin
        if (pick < 85)      send_item(KIND_DATA, 8'($urandom_range(1)) + CharZero);
        else if (pick < 95) send_item(KIND_DATA, 8'($urandom));
        else                send_item(KIND_RESTART, 8'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned src_mix  [4] = '{0, 68, 0, 11};
    int unsigned sink_mix [4] = '{0, 0, 68, 11};
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = src_mix[p];
      sink_stall_pct = sink_mix[p];
      for (int b = 0; b < int'(BatchesPerMix); b++) begin
        write_config(mode_e'($urandom_range(1)), pick_key_len(), pick_key_word(),
                     pick_key_word(), pick_key_word(), pick_key_word());
        send_random_items(ItemsPerBatch);
        drain_block();
      end
    end
  endtask

  always begin
    @(hold_start);
    holding <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    holding <= 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= !holding && ($urandom_range(99) >= sink_stall_pct);
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected item: byte_out %0d last %0d", out_if.byte_out, out_if.last);
        fail_count++;
      end else begin
        exp_item = expected_q.pop_front();
        if (out_if.byte_out !== exp_item.byte_out) begin
          $error("byte_out: expected %0d, got %0d", exp_item.byte_out, out_if.byte_out);
          fail_count++;
        end
        if (out_if.last !== exp_item.last) begin
          $error("last: expected %0d, got %0d", exp_item.last, out_if.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_count <= 0;
      end else if (stall_count >= WatchdogLimit) begin
        $display("tb_top failed");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < int'(KeyRegs); i++) cfg_key[i] = '0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_if.valid   = 1'b0;
    in_if.kind    = KIND_DATA;
    in_if.char_in = '0;
    out_if.ready  = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_encrypt_extremes();
    test_decrypt_groups();
    test_backpressure();
    test_random_traffic();
    drain_block();

    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pakc_pkg.sv
rtl/pakc_in_if.sv
rtl/pakc_out_if.sv
rtl/printable_ascii_keyed_shift_cipher.sv
verif/tb_top.sv
